// File: hdl/page_frame_free_list_allocator_assert.svh
// Assertion macros for the page-frame free-list allocator.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PFFLA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PFFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pffla_pkg.sv
// Shared types and constants of the page-frame free-list allocator.
// No dependencies; every other file but pffla_ram and the assertion header imports it.
package pffla_pkg;

  localparam int unsigned MAX_PAGES  = 65536;
  localparam int unsigned SLOT_W     = $clog2(MAX_PAGES);
  localparam int unsigned FREE_W     = 17;
  localparam int unsigned PAGES_W    = FREE_W + 1;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ALLOC,
    CMD_FREE,
    CMD_IGNORE
  } cmd_op_t;

  typedef struct packed {
    logic [1:0]        func;
    logic              region_usable;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_length;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;
    logic [FREE_W-1:0] free_pages;
  } result_t;

  // Classified command: page is the first load page or the freed page,
  // pages is the load page count, all ones from 131072 whole pages up.
  typedef struct packed {
    cmd_op_t            op;
    logic [PFN_W-1:0]   page;
    logic [PAGES_W-1:0] pages;
  } cmd_t;

endpackage

// File: hdl/pffla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pffla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/pffla_front.sv
// Front end: accepts input beats and classifies them into commands.
// Depends on pffla_pkg.
module pffla_front (
  input  logic                                push,
  output logic                                full,
  input  pffla_pkg::item_t                    item,
  input  logic [pffla_pkg::ADDR_W-1:0]        offset,
  input  logic                                q_full,
  output logic                                q_push,
  output pffla_pkg::cmd_t                     q_data
);
  import pffla_pkg::*;

  logic [PFN_W-1:0]  len_hi;
  logic              len_frac;
  logic              len_big;
  logic [ADDR_W-1:0] free_phys;

  assign full   = q_full;
  assign q_push = push & ~q_full;

  // Page count rounded up, saturated to all ones from 131072 whole pages up
  assign len_hi   = item.region_length[ADDR_W-1:PAGE_SHIFT];
  assign len_frac = |item.region_length[PAGE_SHIFT-1:0];
  assign len_big  = |len_hi[PFN_W-1:FREE_W];

  // Freed address back to physical
  assign free_phys = item.address - offset;

  // Classify
  always_comb begin
    q_data.op    = CMD_IGNORE;
    q_data.page  = item.address[ADDR_W-1:PAGE_SHIFT];
    q_data.pages = len_big ? '1 : ({1'b0, len_hi[FREE_W-1:0]} + PAGES_W'(len_frac));
    case (item.func)
      FUNC_LOAD: begin
        if (item.region_usable && (item.address != '0)) begin
          q_data.op = CMD_LOAD;
        end
      end
      FUNC_ALLOC: begin
        q_data.op = CMD_ALLOC;
      end
      FUNC_FREE: begin
        if (item.address != '0) begin
          q_data.op   = CMD_FREE;
          q_data.page = free_phys[ADDR_W-1:PAGE_SHIFT];
        end
      end
      default: begin
        q_data.op = CMD_IGNORE;
      end
    endcase
  end

endmodule

// File: hdl/pffla_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on pffla_pkg.
module pffla_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pffla_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            pop,
  output pffla_pkg::cmd_t rd_data,
  output logic            valid
);
  import pffla_pkg::*;

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entries [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(CMDQ_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = entries[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/pffla_back.sv
// Back end: executes commands on the free-page ring and holds the result.
// Depends on pffla_pkg and pffla_ram.
module pffla_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  pffla_pkg::cmd_t              cmd,
  output logic                         cmd_pop,
  input  logic [pffla_pkg::ADDR_W-1:0] offset,
  output logic                         empty,
  input  logic                         pop,
  output pffla_pkg::result_t           result
);
  import pffla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_ALLOC
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] front_index;
  logic [SLOT_W-1:0] back_index;
  logic [FREE_W-1:0] free_count;
  logic [PFN_W-1:0]  load_page;
  logic [FREE_W-1:0] load_left;
  logic              load_full;
  logic              out_valid;
  result_t           result_q;

  logic [SLOT_W-1:0] front_next;
  logic [SLOT_W-1:0] front_prev;
  logic [SLOT_W-1:0] back_next;
  logic [FREE_W-1:0] room;
  logic              ring_empty;
  logic              ring_full;
  logic              take;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [PFN_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [PFN_W-1:0]  ram_rdata;

  assign empty   = ~out_valid;
  assign result  = result_q;
  assign cmd_pop = take;

  // Ring slot arithmetic and occupancy
  assign front_next = (front_index == SLOT_W'(MAX_PAGES - 1)) ? '0 : front_index + 1'b1;
  assign front_prev = (front_index == '0) ? SLOT_W'(MAX_PAGES - 1) : front_index - 1'b1;
  assign back_next  = (back_index == SLOT_W'(MAX_PAGES - 1)) ? '0 : back_index + 1'b1;
  assign room       = FREE_W'(MAX_PAGES) - free_count;
  assign ring_empty = (free_count == '0);
  assign ring_full  = (free_count == FREE_W'(MAX_PAGES));

  // Start a command only when the result slot is free or drains now
  assign take = (state == S_IDLE) && cmd_valid && (!out_valid || pop);

  // Ring memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = back_index;
    ram_wdata = load_page;
    ram_re    = 1'b0;
    case (state)
      S_IDLE: begin
        if (take && (cmd.op == CMD_ALLOC) && !ring_empty) begin
          ram_re = 1'b1;
        end
        if (take && (cmd.op == CMD_FREE) && !ring_full) begin
          ram_we    = 1'b1;
          ram_waddr = front_prev;
          ram_wdata = cmd.page;
        end
      end
      S_LOAD: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pffla_ram #(
    .WIDTH (PFN_W),
    .DEPTH (MAX_PAGES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (front_index),
    .rdata (ram_rdata)
  );

  // Sequencer, ring pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      back_index  <= '0;
      free_count  <= '0;
      load_left   <= '0;
      load_full   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Drop the result once taken
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            result_q.page_address <= '0;
            result_q.free_pages   <= free_count;
            case (cmd.op)
              CMD_ALLOC: begin
                if (ring_empty) begin
                  result_q.status <= ST_OOM;
                  out_valid       <= 1'b1;
                end else begin
                  front_index <= front_next;
                  free_count  <= free_count - 1'b1;
                  state       <= S_ALLOC;
                end
              end
              CMD_FREE: begin
                if (ring_full) begin
                  result_q.status <= ST_FULL;
                end else begin
                  front_index         <= front_prev;
                  free_count          <= free_count + 1'b1;
                  result_q.status     <= ST_OK;
                  result_q.free_pages <= free_count + 1'b1;
                end
                out_valid <= 1'b1;
              end
              CMD_LOAD: begin
                if (cmd.pages == '0) begin
                  result_q.status <= ST_OK;
                  out_valid       <= 1'b1;
                end else if (room == '0) begin
                  result_q.status <= ST_FULL;
                  out_valid       <= 1'b1;
                end else begin
                  load_page <= cmd.page;
                  load_full <= (cmd.pages > {1'b0, room});
                  load_left <= (cmd.pages > {1'b0, room}) ? room : cmd.pages[FREE_W-1:0];
                  state     <= S_LOAD;
                end
              end
              default: begin
                result_q.status <= ST_IGNORED;
                out_valid       <= 1'b1;
              end
            endcase
          end
        end
        // Append one page per cycle at the tail
        S_LOAD: begin
          back_index <= back_next;
          load_page  <= load_page + 1'b1;
          free_count <= free_count + 1'b1;
          load_left  <= load_left - 1'b1;
          if (load_left == FREE_W'(1)) begin
            result_q.status       <= load_full ? ST_FULL : ST_OK;
            result_q.page_address <= '0;
            result_q.free_pages   <= free_count + 1'b1;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        // Ring read data is back: form the virtual address
        S_ALLOC: begin
          result_q.status       <= ST_OK;
          result_q.page_address <= {ram_rdata, PAGE_SHIFT'(0)} + offset;
          result_q.free_pages   <= free_count;
          out_valid             <= 1'b1;
          state                 <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/page_frame_free_list_allocator.sv
// Page-frame free-list allocator: holds free 4 KiB page numbers in a 65536-entry ring used
// as a deque. Items enter through a two-deep command queue, so the input keeps accepting
// while the back end works or a result waits to be popped, until two items are queued.
// The back end runs one command at a time against a single-port-per-direction ring memory:
// an ignored item, a free or an alloc on an empty ring completes from the idle state, an
// alloc that finds a page forms its result in S_ALLOC (the ring read is registered), and a
// region load stores its pages in S_LOAD, since the ring is written one page per cycle.
// The ring holds no reset value; only entries written by a load or a free are ever read.
// Each item yields exactly one result, held in an output register until popped.
// Depends on pffla_pkg, pffla_front, pffla_cmd_fifo and pffla_back.
module page_frame_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  pffla_pkg::item_t             item,
  output logic                         empty,
  input  logic                         pop,
  output pffla_pkg::result_t           result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pffla_pkg::ADDR_W-1:0] cfg_data
);
  import pffla_pkg::*;

  logic [ADDR_W-1:0] direct_map_offset;
  logic              q_push;
  logic              q_full;
  cmd_t              q_wr_data;
  cmd_t              q_rd_data;
  logic              q_valid;
  logic              q_pop;

  // Offset register, to be written only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      direct_map_offset <= '0;
    end else if (cfg_valid) begin
      direct_map_offset <= cfg_data;
    end
  end

  pffla_front u_front (
    .push   (push),
    .full   (full),
    .item   (item),
    .offset (direct_map_offset),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  pffla_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .valid   (q_valid)
  );

  pffla_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_rd_data),
    .cmd_pop   (q_pop),
    .offset    (direct_map_offset),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: hdl/pffla_checker.sv
// Port-level checks on the allocator's results, bound to the top level.
// Depends on pffla_pkg and page_frame_free_list_allocator_assert.svh.
`include "page_frame_free_list_allocator_assert.svh"

module pffla_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input pffla_pkg::result_t result
);
  import pffla_pkg::*;

  logic [FREE_W-1:0] cap_pages;
  logic              fail_shown;
  logic              oom_shown;
  logic              full_shown;

  assign cap_pages  = FREE_W'(MAX_PAGES);
  assign fail_shown = !empty && (result.status != ST_OK);
  assign oom_shown  = !empty && (result.status == ST_OOM);
  assign full_shown = !empty && (result.status == ST_FULL);

  // Only a successful alloc carries an address
  `PFFLA_ASSERT_SAME(a_addr_zero, fail_shown, result.page_address == '0, "stray address")

  // Out of memory only with nothing held
  `PFFLA_ASSERT_SAME(a_oom_empty, oom_shown, result.free_pages == '0, "oom with pages held")

  // Store full only with the ring at capacity
  `PFFLA_ASSERT_SAME(a_full_cap, full_shown, result.free_pages == cap_pages, "full under cap")

  // No result right after reset
  `PFFLA_ASSERT_SAME(a_reset_empty, $past(rst), empty, "result present after reset")

  // Hold a waiting result until it is popped
  `PFFLA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result moved")

endmodule

bind page_frame_free_list_allocator pffla_checker u_checker (.*);

// File: sim/tb_page_frame_free_list_allocator.sv
// Testbench for the page-frame free-list allocator: directed corner items, then random
// region loads, allocs and frees under several direct-map offsets, checked by a scoreboard.
// Depends on pffla_pkg and page_frame_free_list_allocator.
`timescale 1ns / 1ps

module tb_page_frame_free_list_allocator;
  import pffla_pkg::*;

  localparam int unsigned RUN_LIMIT = 1_000_000;
  localparam int unsigned SEG_ITEMS = 350;

  // Free-page pool predictor plus the queue of replies still due from the block.
  class free_list_scoreboard;
    bit [PFN_W-1:0]    pages_ring [MAX_PAGES];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    int unsigned       held;
    int unsigned       peak_held;
    logic [ADDR_W-1:0] offset;
    result_t           due[$];
    logic [ADDR_W-1:0] handed_out[$];
    int unsigned       mismatches;
    int unsigned       replies;
    int unsigned       n_load;
    int unsigned       n_alloc;
    int unsigned       n_free;
    int unsigned       n_other;

    function new();
      offset = '0;
    endfunction

    // Apply one accepted item to the pool and queue the reply it must produce.
    function void account_item(item_t it);
      result_t           want;
      logic [ADDR_W-1:0] n_pages;
      logic [ADDR_W-1:0] room;
      logic [ADDR_W-1:0] diff;
      bit [PFN_W-1:0]    pfn;
      want = '0;
      want.status = ST_OK;
      case (func_t'(it.func))
        FUNC_LOAD: begin
          n_load++;
          if (!it.region_usable || it.address == '0) begin
            want.status = ST_IGNORED;
          end else begin
            n_pages = (it.region_length >> PAGE_SHIFT)
                    + ADDR_W'(it.region_length[PAGE_SHIFT-1:0] != '0);
            room = ADDR_W'(MAX_PAGES - held);
            if (n_pages > room) begin
              n_pages = room;
              want.status = ST_FULL;
            end
            pfn = it.address[ADDR_W-1:PAGE_SHIFT];
            repeat (n_pages) begin
              pages_ring[tail_slot] = pfn;
              pfn++;
              tail_slot = (tail_slot + 1) % MAX_PAGES;
              held++;
            end
          end
        end
        FUNC_ALLOC: begin
          n_alloc++;
          if (held == 0) begin
            want.status = ST_OOM;
          end else begin
            want.page_address = {pages_ring[head_slot], {PAGE_SHIFT{1'b0}}} + offset;
            handed_out.push_back(want.page_address);
            head_slot = (head_slot + 1) % MAX_PAGES;
            held--;
          end
        end
        FUNC_FREE: begin
          n_free++;
          if (it.address == '0) begin
            want.status = ST_IGNORED;
          end else if (held >= MAX_PAGES) begin
            want.status = ST_FULL;
          end else begin
            // Freed pages go back at the head so they are reused first.
            head_slot = (head_slot + MAX_PAGES - 1) % MAX_PAGES;
            diff = it.address - offset;
            pages_ring[head_slot] = diff[ADDR_W-1:PAGE_SHIFT];
            held++;
          end
        end
        default: begin
          n_other++;
          want.status = ST_IGNORED;
        end
      endcase
      want.free_pages = FREE_W'(held);
      if (held > peak_held) peak_held = held;
      due.push_back(want);
    endfunction

    task flag(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      mismatches++;
      $display("mismatch at reply %0d: %s got %h want %h", replies, what, got, want);
    endtask

    // Compare one popped reply with the oldest one due.
    task check_reply(result_t got);
      result_t want;
      replies++;
      if (due.size() == 0) begin
        flag("reply with no item pending, page_address", got.page_address, '0);
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status)
        flag("status", ADDR_W'(got.status), ADDR_W'(want.status));
      if (got.page_address !== want.page_address)
        flag("page_address", got.page_address, want.page_address);
      if (got.free_pages !== want.free_pages)
        flag("free_pages", ADDR_W'(got.free_pages), ADDR_W'(want.free_pages));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  item_t             item;
  logic              empty;
  logic              pop = 1'b0;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data;

  free_list_scoreboard sb = new();
  int unsigned         burst_left = 0;
  int unsigned         pool_cap = 40;
  int unsigned         cfg_writes = 0;
  int unsigned         cycle_count = 0;
  logic [7:0]          pop_mask = 8'hFF;
  logic [4:0]          pop_phase = '0;

  page_frame_free_list_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: pick a new pop pattern whenever the 5-bit phase wraps, often one with no stall.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop_phase <= pop_phase + 1'b1;
      if (pop_phase == '0)
        pop_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      pop <= pop_mask[pop_phase[2:0]];
    end
  end

  // Observe every beat on the three channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_reply(result);
      if (push && !full) sb.account_item(item);
      if (cfg_valid && cfg_ready) begin
        sb.offset = cfg_data;
        cfg_writes++;
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout with %0d replies still due", sb.due.size());
      $display("[page_frame_free_list_allocator] ERROR");
      $finish;
    end
  end

  function automatic item_t mk(logic [1:0] func, logic usable, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] len);
    item_t it;
    it.func = func;
    it.region_usable = usable;
    it.address = addr;
    it.region_length = len;
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed loads, allocs and frees of handed-out pages; some noise.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned idx;
    it = mk(FUNC_NONE, 1'($urandom), rand64(), rand64());
    pick = $urandom_range(0, 99);
    if (pick < 22 && sb.held > pool_cap) pick = 40;
    if (pick < 22) begin
      it.func = FUNC_LOAD;
      it.region_usable = 1'b1;
      if ($urandom_range(0, 3) == 0) it.address = 64'($urandom_range(1, 1 << 20));
      if (it.address == '0) it.address = 64'h1000;
      it.region_length = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 64 * 4096))
                                                      : 64'($urandom_range(0, 8 * 4096));
    end else if (pick < 30) begin
      // Ignored region: unusable or based at zero, length fully random.
      it.func = FUNC_LOAD;
      if ($urandom_range(0, 1) == 0) it.region_usable = 1'b0;
      else it.address = '0;
    end else if (pick < 65) begin
      it.func = FUNC_ALLOC;
    end else if (pick < 95) begin
      it.func = FUNC_FREE;
      if (pick < 82 && sb.handed_out.size() != 0) begin
        idx = $urandom_range(0, sb.handed_out.size() - 1);
        it.address = sb.handed_out[idx] + 64'($urandom_range(0, 4095));
        sb.handed_out.delete(idx);
      end else if (pick >= 91) begin
        it.address = '0;
      end
    end
    return it;
  endfunction

  // Send one item, opening a random gap at the start of each burst.
  task automatic send_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Hold the input until every due reply has been popped, then let the block settle.
  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_offset(input logic [ADDR_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed corners with the offset still at its reset value.
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_FREE, 1'b1, '0, '1));
    send_item(mk(FUNC_NONE, 1'b1, '1, '1));
    send_item(mk(FUNC_LOAD, 1'b0, 64'h1000, 64'h3000));
    send_item(mk(FUNC_LOAD, 1'b1, '0, 64'h5000));
    send_item(mk(FUNC_LOAD, 1'b1, 64'h1000, '0));
    send_item(mk(FUNC_LOAD, 1'b1, 64'h12345, 64'h2001));
    send_item(mk(FUNC_LOAD, 1'b1, 64'hFFFF_FFFF_FFFF_F000, 64'h3000));
    send_item(mk(FUNC_LOAD, 1'b1, 64'h7000, 64'h1));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_FREE, 1'b0, 64'h5000, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_FREE, 1'b0, '1, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));

    // Offset arithmetic: a free below the offset wraps, an alloc wraps on the add.
    set_offset(64'hFFFF_8000_0000_0000);
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_FREE, 1'b0, 64'h3000, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    set_offset('1);
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_FREE, 1'b0, 64'h4FFF, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));

    // Random segments, each under its own offset and pool size.
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin set_offset(rand64()); pool_cap = 40; end
        1: begin set_offset('0); pool_cap = 2000; end
        2: begin set_offset('1); pool_cap = 8; end
        default: begin set_offset(rand64()); pool_cap = 300; end
      endcase
      repeat (SEG_ITEMS) send_item(random_item());
    end

    // Capacity: fill the ring with one huge region, then poke at the full pool.
    set_offset(64'hFFFF_8000_0000_0000);
    send_item(mk(FUNC_LOAD, 1'b1, rand64() | 64'h1000, '1));
    send_item(mk(FUNC_FREE, 1'b0, rand64() | 64'h1, '0));
    send_item(mk(FUNC_LOAD, 1'b1, 64'h2000, 64'h1000));
    send_item(mk(FUNC_LOAD, 1'b1, 64'h2000, '0));
    send_item(mk(FUNC_FREE, 1'b0, '0, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));
    send_item(mk(FUNC_FREE, 1'b0, rand64() | 64'h1, '0));
    send_item(mk(FUNC_LOAD, 1'b0, rand64(), '1));
    send_item(mk(FUNC_NONE, 1'b0, '0, '0));
    send_item(mk(FUNC_ALLOC, 1'b0, '0, '0));

    drain_results();
    $display("covered %0d items: %0d loads, %0d allocs, %0d frees, %0d undefined funcs",
             sb.n_load + sb.n_alloc + sb.n_free + sb.n_other, sb.n_load, sb.n_alloc,
             sb.n_free, sb.n_other);
    $display("checked %0d replies over %0d offset writes, peak pool %0d pages, %0d mismatches",
             sb.replies, cfg_writes, sb.peak_held, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[page_frame_free_list_allocator] OK");
    end else begin
      $display("[page_frame_free_list_allocator] ERROR");
    end
    $finish;
  end

endmodule
